FILE: sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Default sizes of the queue.
  localparam int DEPTH_DEF         = 64;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int PAYLOAD_BITS_DEF  = 64;

  // Command codes carried on the request channel.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // Result status codes.
  localparam int STATUS_BITS = 2;
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  // Operation broadcast to every cell of the chain at once.
  typedef struct packed {
    logic insert;
    logic pop;
  } spq_op_t;

endpackage

`default_nettype wire

FILE: sv/spq_if.sv
`default_nettype none

interface spq_req_if #(
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic signed [PRIORITY_BITS-1:0] priority_req;
  logic [PAYLOAD_BITS-1:0]         payload;

  modport source (output valid, command, priority_req, payload, input ready);
  modport sink   (input valid, command, priority_req, payload, output ready);
endinterface

interface spq_rsp_if #(
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [spq_pkg::STATUS_BITS-1:0]    status;
  logic signed [PRIORITY_BITS-1:0]    out_priority;
  logic [PAYLOAD_BITS-1:0]            out_payload;

  modport source (output valid, status, out_priority, out_payload, input ready);
  modport sink   (input valid, status, out_priority, out_payload, output ready);
endinterface

`default_nettype wire

FILE: sv/spq_cell.sv
`default_nettype none

// One slot of the sorted chain. On an insert a slot keeps its entry if it
// ranks at or above the new key, otherwise it takes the new entry or the
// entry of its left neighbour. On a pop it takes its right neighbour.
module spq_cell #(
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire spq_pkg::spq_op_t    op,
  input  wire [PRIORITY_BITS-1:0]  key,
  input  wire [PAYLOAD_BITS-1:0]   key_payload,
  input  wire                      left_valid,
  input  wire                      left_behind,
  input  wire [PRIORITY_BITS-1:0]  left_pri,
  input  wire [PAYLOAD_BITS-1:0]   left_pay,
  input  wire                      right_valid,
  input  wire [PRIORITY_BITS-1:0]  right_pri,
  input  wire [PAYLOAD_BITS-1:0]   right_pay,
  output logic                     valid,
  output logic [PRIORITY_BITS-1:0] pri,
  output logic [PAYLOAD_BITS-1:0]  pay,
  output logic                     behind
);

  logic                     take_new;
  logic                     take_left;
  logic                     valid_next;
  logic [PRIORITY_BITS-1:0] pri_next;
  logic [PAYLOAD_BITS-1:0]  pay_next;

  // The new entry goes behind every stored entry of equal or higher rank.
  assign behind    = valid && ($signed(pri) >= $signed(key));
  assign take_new  = op.insert && !behind && left_behind;
  assign take_left = op.insert && !behind && !left_behind;

  always_comb begin
    valid_next = valid;
    pri_next   = pri;
    pay_next   = pay;
    priority if (take_new) begin
      valid_next = 1'b1;
      pri_next   = key;
      pay_next   = key_payload;
    end else if (take_left) begin
      valid_next = left_valid;
      pri_next   = left_pri;
      pay_next   = left_pay;
    end else if (op.pop) begin
      valid_next = right_valid;
      pri_next   = right_pri;
      pay_next   = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pri <= pri_next;
    pay <= pay_next;
  end

endmodule

`default_nettype wire

FILE: sv/sorted_priority_queue.sv
// Sorted priority queue of DEPTH entries, each a signed priority and an
// opaque payload, held in a row of identical cells in descending priority
// order. Every request beat (insert or pop) yields exactly one response beat.
// An insert places the entry behind all stored entries of equal or higher
// priority, so equal priorities leave in arrival order; an insert into a
// full queue is dropped with status full. A pop returns the front entry, or
// status empty when nothing is stored. One request beat is taken per clock
// cycle and its response appears in the output register on the next cycle;
// the request channel stalls only while that register holds a beat that has
// not been taken. The cost of a cycle is set by the key comparison, which is
// broadcast to every cell at once and resolved inside each cell.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
) (
  input wire        clk,
  input wire        rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  // Per-cell state, read by the neighbouring cells and, at the two ends, by the status and response logic.
  logic                     cell_valid  [DEPTH];
  logic                     cell_behind [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_pri    [DEPTH];
  logic [PAYLOAD_BITS-1:0]  cell_pay    [DEPTH];

  spq_pkg::spq_op_t op;
  logic             accept;
  logic             empty;
  logic             full;

  // The queue is full when the last cell holds an entry, and empty when the
  // front cell holds none, because entries always pack towards the front.
  assign empty  = !cell_valid[0];
  assign full   = cell_valid[DEPTH-1];

  // A new beat is taken whenever the response register is free or is being
  // emptied in this same cycle.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign op.insert = accept && (req.command == spq_pkg::CMD_INSERT) && !full;
  assign op.pop    = accept && (req.command == spq_pkg::CMD_POP) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_valid;
    logic                     l_behind;
    logic [PRIORITY_BITS-1:0] l_pri;
    logic [PAYLOAD_BITS-1:0]  l_pay;
    logic                     r_valid;
    logic [PRIORITY_BITS-1:0] r_pri;
    logic [PAYLOAD_BITS-1:0]  r_pay;

    // The front cell sees an imaginary left neighbour that always ranks
    // ahead, so it loads the new entry when it is empty or its entry ranks below the key.
    if (i == 0) begin : g_front
      assign l_valid  = 1'b0;
      assign l_behind = 1'b1;
      assign l_pri    = '0;
      assign l_pay    = '0;
    end else begin : g_mid
      assign l_valid  = cell_valid[i-1];
      assign l_behind = cell_behind[i-1];
      assign l_pri    = cell_pri[i-1];
      assign l_pay    = cell_pay[i-1];
    end

    // The last cell empties on a pop.
    if (i == DEPTH - 1) begin : g_back
      assign r_valid = 1'b0;
      assign r_pri   = '0;
      assign r_pay   = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_pri   = cell_pri[i+1];
      assign r_pay   = cell_pay[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .key        (req.priority_req),
      .key_payload(req.payload),
      .left_valid (l_valid),
      .left_behind(l_behind),
      .left_pri   (l_pri),
      .left_pay   (l_pay),
      .right_valid(r_valid),
      .right_pri  (r_pri),
      .right_pay  (r_pay),
      .valid      (cell_valid[i]),
      .pri        (cell_pri[i]),
      .pay        (cell_pay[i]),
      .behind     (cell_behind[i])
    );
  end

  // Response register. The result is formed from the queue as it stands
  // before this cycle's update: the front cell still holds the entry being
  // popped.
  logic [spq_pkg::STATUS_BITS-1:0] status_next;
  logic [PRIORITY_BITS-1:0]        rsp_pri_next;
  logic [PAYLOAD_BITS-1:0]         rsp_pay_next;

  always_comb begin
    status_next  = spq_pkg::ST_OK;
    rsp_pri_next = '0;
    rsp_pay_next = '0;
    unique case (req.command)
      spq_pkg::CMD_INSERT: begin
        if (full) begin
          status_next = spq_pkg::ST_FULL;
        end
      end
      spq_pkg::CMD_POP: begin
        if (empty) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          rsp_pri_next = cell_pri[0];
          rsp_pay_next = cell_pay[0];
        end
      end
      default: begin
        status_next = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status       <= status_next;
      rsp.out_priority <= rsp_pri_next;
      rsp.out_payload  <= rsp_pay_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/spq_checker.sv
`default_nettype none

module spq_checker #(
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
) (
  input wire                            clk,
  input wire                            rst,
  input wire                            req_valid,
  input wire                            req_ready,
  input wire                            req_command,
  input wire                            rsp_valid,
  input wire                            rsp_ready,
  input wire [spq_pkg::STATUS_BITS-1:0] rsp_status,
  input wire [PRIORITY_BITS-1:0]        rsp_priority,
  input wire [PAYLOAD_BITS-1:0]         rsp_payload
);

  // A stalled response beat stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat withdrawn while stalled");

  // Every accepted request shows its response on the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no response after accepted request");

  // An insert never reports empty, and a pop never reports full.
  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=>
      (($past(req_command) == spq_pkg::CMD_INSERT) && (rsp_status != spq_pkg::ST_EMPTY))
      || (($past(req_command) == spq_pkg::CMD_POP) && (rsp_status != spq_pkg::ST_FULL)))
    else $error("status does not match command");

  // Only a successful pop carries data.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != spq_pkg::ST_OK) |->
      (rsp_priority == '0) && (rsp_payload == '0))
    else $error("error response carries data");

endmodule

bind sorted_priority_queue spq_checker #(
  .PRIORITY_BITS(PRIORITY_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_command (req.command),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_priority(rsp.out_priority),
  .rsp_payload (rsp.out_payload)
);

`default_nettype wire

FILE: verif/spq_checker.sv
`default_nettype none

// Watches both channels of the sorted priority queue, keeps its own sorted
// list of entries and compares every response beat with the result owed to
// the oldest request beat not yet answered.
module spq_scoreboard (
  input wire  clk,
  input wire  rst,
  spq_req_if  req,
  spq_rsp_if  rsp,
  output int  fail_count,
  output int  awaited
);

  localparam int SLOTS = spq_pkg::DEPTH_DEF;
  localparam int PRI_W = spq_pkg::PRIORITY_BITS_DEF;
  localparam int PAY_W = spq_pkg::PAYLOAD_BITS_DEF;

  typedef struct {
    logic [spq_pkg::STATUS_BITS-1:0] status;
    logic signed [PRI_W-1:0]         pri;
    logic [PAY_W-1:0]                pay;
  } outcome_t;

  logic signed [PRI_W-1:0] held_pri [SLOTS];
  logic [PAY_W-1:0]        held_pay [SLOTS];
  int                      held_count;
  outcome_t                owed [$];

  // Applies one request to the local list and returns the response it owes.
  function automatic outcome_t apply_request(logic cmd, logic signed [PRI_W-1:0] pri,
                                             logic [PAY_W-1:0] pay);
    outcome_t res;
    int       slot;
    int       i;
    res.status = spq_pkg::ST_OK;
    res.pri    = '0;
    res.pay    = '0;
    if (cmd == spq_pkg::CMD_INSERT) begin
      if (held_count == SLOTS) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // Equal priorities stay in arrival order: skip past them.
        slot = 0;
        while (slot < held_count && held_pri[slot] >= pri) slot++;
        for (i = held_count; i > slot; i--) begin
          held_pri[i] = held_pri[i-1];
          held_pay[i] = held_pay[i-1];
        end
        held_pri[slot] = pri;
        held_pay[slot] = pay;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.pri = held_pri[0];
        res.pay = held_pay[0];
        for (i = 1; i < held_count; i++) begin
          held_pri[i-1] = held_pri[i];
          held_pay[i-1] = held_pay[i];
        end
        held_count--;
      end
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    awaited    = 0;
    held_count = 0;
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      owed.delete();
      held_count = 0;
      awaited <= 0;
    end else begin
      if (req.valid && req.ready)
        owed.push_back(apply_request(req.command, req.priority_req, req.payload));
      if (rsp.valid && rsp.ready) begin
        if (owed.size() == 0) begin
          $display("%0t: response beat with nothing owed: status %0d priority %0d payload %h",
                   $time, rsp.status, rsp.out_priority, rsp.out_payload);
          fail_count++;
        end else begin
          want = owed.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, rsp.status);
            fail_count++;
          end
          if (rsp.out_priority !== want.pri) begin
            $display("%0t: priority expected %0d, got %0d", $time, want.pri,
                     rsp.out_priority);
            fail_count++;
          end
          if (rsp.out_payload !== want.pay) begin
            $display("%0t: payload expected %h, got %h", $time, want.pay, rsp.out_payload);
            fail_count++;
          end
        end
      end
      awaited <= owed.size();
    end
  end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

// Top of the bench. It makes the clock and reset, drives request beats into
// the queue, stalls the response channel at random and gives the verdict.
// All prediction and comparison live in the scoreboard beside the block.
module testbench;

  localparam int PRI_W       = spq_pkg::PRIORITY_BITS_DEF;
  localparam int PAY_W       = spq_pkg::PAYLOAD_BITS_DEF;
  localparam int SLOTS       = spq_pkg::DEPTH_DEF;
  localparam int RANDOM_BEATS = 800;
  // Far beyond the slowest legal run: every beat waiting out the longest
  // sender gap and the longest response stall, several times over.
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst;
  int   cycles;
  int   fail_count;
  int   awaited;

  spq_req_if #(.PRIORITY_BITS(PRI_W), .PAYLOAD_BITS(PAY_W)) req_ch ();
  spq_rsp_if #(.PRIORITY_BITS(PRI_W), .PAYLOAD_BITS(PAY_W)) rsp_ch ();

  sorted_priority_queue #(
    .DEPTH(SLOTS), .PRIORITY_BITS(PRI_W), .PAYLOAD_BITS(PAY_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  spq_scoreboard watch (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .fail_count(fail_count),
    .awaited(awaited)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: a run that has not finished by now has lost a beat or hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Gap lengths are mostly nothing, sometimes short and now and then
  // a long stretch, so that idle cycles land on every phase of the queue.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Priorities are drawn so that ties are common (the arrival-order rule
  // only shows with equal keys) while the full signed range is still swept.
  function automatic logic signed [PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return PRI_W'($urandom_range(0, 3) - 2);
      1: begin
        case ($urandom_range(0, 3))
          0: return {1'b0, {(PRI_W-1){1'b1}}};
          1: return {1'b1, {(PRI_W-1){1'b0}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return PRI_W'($urandom);
    endcase
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    return {$urandom, $urandom};
  endfunction

  // Response side: random stalls, with calm stretches in which the sink
  // takes every beat so the one-beat-per-cycle rate is exercised as well.
  int unsigned hold;
  int unsigned calm;

  always @(posedge clk) begin
    int unsigned g;
    if (hold != 0) begin
      rsp_ch.ready <= 1'b0;
      hold <= hold - 1;
    end else if (calm != 0) begin
      rsp_ch.ready <= 1'b1;
      calm <= calm - 1;
    end else begin
      g = gap_len();
      if (g == 0) begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 19) == 0) calm <= $urandom_range(20, 80);
      end else begin
        rsp_ch.ready <= 1'b0;
        hold <= g - 1;
      end
    end
  end

  // Presents one request beat and returns at the edge on which it is taken.
  // The valid line stays high, so a following beat can go out back to back.
  task automatic send_beat(logic cmd, logic signed [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.priority_req <= pri;
    req_ch.payload      <= pay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drops valid for the given rest; the payload lines carry junk meanwhile,
  // which the queue must ignore.
  task automatic rest(int unsigned n);
    if (n != 0) begin
      req_ch.valid        <= 1'b0;
      req_ch.command      <= 1'($urandom);
      req_ch.priority_req <= PRI_W'($urandom);
      req_ch.payload      <= pick_payload();
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits until every owed response has come back.
  task automatic drain_responses();
    rest(1);
    while (awaited != 0) @(posedge clk);
  endtask

  initial begin
    int       sent;
    int       run;
    int       kind;
    int       insert_pct;
    bit       quiet;
    int       i;

    cycles              = 0;
    hold                = 0;
    calm                = 0;
    rst                 = 1'b1;
    rsp_ch.ready        = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.command      = spq_pkg::CMD_INSERT;
    req_ch.priority_req = '0;
    req_ch.payload      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A pop on the empty queue first, then the extreme
    // priorities and payloads, three entries of equal priority to show that
    // ties leave in arrival order, and finally pops until the queue has run
    // dry once more.
    send_beat(spq_pkg::CMD_POP, '0, '0);
    send_beat(spq_pkg::CMD_INSERT, '0, '0);
    send_beat(spq_pkg::CMD_INSERT, {1'b0, {(PRI_W-1){1'b1}}}, '1);
    send_beat(spq_pkg::CMD_INSERT, {1'b1, {(PRI_W-1){1'b0}}},
              {1'b1, {(PAY_W-2){1'b0}}, 1'b1});
    send_beat(spq_pkg::CMD_INSERT, 16'sd5, {(PAY_W/2){2'b01}});
    rest(2);
    send_beat(spq_pkg::CMD_INSERT, 16'sd5, {(PAY_W/2){2'b10}});
    send_beat(spq_pkg::CMD_INSERT, -16'sd1, 64'h0123_4567_89ab_cdef);
    send_beat(spq_pkg::CMD_INSERT, 16'sd1, 64'hfedc_ba98_7654_3210);
    send_beat(spq_pkg::CMD_INSERT, 16'sd5, 64'h0000_0000_ffff_ffff);
    for (i = 0; i < 9; i++) begin
      send_beat(spq_pkg::CMD_POP, PRI_W'($urandom), pick_payload());
      if (i == 4) rest(3);
    end
    drain_responses();

    // Random part, in runs of differing character. The first run fills the
    // queue past its depth so that dropped inserts are seen, the second is
    // mostly pops, and later runs mix the two in random measure.
    sent = 0;
    run  = 0;
    while (sent < RANDOM_BEATS) begin
      if (run == 0) begin
        kind = 0;
      end else if (run == 1) begin
        kind = 1;
      end else begin
        kind = $urandom_range(0, 3);
      end
      case (kind)
        0:       insert_pct = 95;
        1:       insert_pct = 10;
        2:       insert_pct = 50;
        default: insert_pct = 65;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (i = 0; i < ((run == 0) ? SLOTS + 10 : $urandom_range(20, 90)); i++) begin
        if ($urandom_range(0, 99) < insert_pct || (run == 0 && i < SLOTS + 2))
          send_beat(spq_pkg::CMD_INSERT, pick_priority(), pick_payload());
        else
          send_beat(spq_pkg::CMD_POP, PRI_W'($urandom), pick_payload());
        sent++;
        if (!quiet) rest(gap_len());
      end
      // The sender holds off until every owed response is back, once for
      // certain after the second run and otherwise now and then.
      if (run == 1 || $urandom_range(0, 3) == 0) drain_responses();
      run++;
    end

    drain_responses();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sorted_priority_queue.f
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
verif/spq_checker.sv
verif/testbench.sv
